// File: rtl/fatlb_pkg.sv
// Shared types and constants for the FIFO fully associative TLB.
`default_nettype none
package fatlb_pkg;

  localparam int PID_W   = 16;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 8;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic               active;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic               found;
    logic [FRAME_W-1:0] frame;
  } query_t;

endpackage
`default_nettype wire

// File: rtl/fatlb_cell.sv
// One TLB slot: stored translation, shift-in from the younger neighbor, and one query stage.
`default_nettype none
module fatlb_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic             load_en,
  input  fatlb_pkg::entry_t new_entry,
  input  fatlb_pkg::entry_t nbr_entry,
  input  logic             nbr_valid,
  output fatlb_pkg::entry_t entry,
  output logic             entry_valid,
  input  fatlb_pkg::query_t q_in,
  output fatlb_pkg::query_t q_out
);
  import fatlb_pkg::*;

  query_t q_next;
  logic   match;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (shift_en) begin
      entry_valid <= nbr_valid;
    end else if (load_en) begin
      entry_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= nbr_entry;
    end else if (load_en) begin
      entry <= new_entry;
    end
  end

  // oldest match wins: once found, later cells pass the query untouched
  assign match = q_in.active && !q_in.found && entry_valid &&
                 (entry.pid == q_in.pid) && (entry.page == q_in.page);

  always_comb begin
    q_next = q_in;
    if (match) begin
      q_next.found = 1'b1;
      q_next.frame = entry.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out <= '0;
    end else begin
      q_out <= q_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fifo_fully_associative_tlb_top.sv
// Top level of the FIFO-replacement fully associative TLB built as a chain of slot cells.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+-------------------------------
//   request | req_valid | req_ready | func, pid, page_number, frame_in
//   result  | rsp_valid | rsp_ready | hit, frame_out, evicted
//
// An insert's result is registered at the request transfer.
// A lookup walks the chain of ENTRIES cells, one cell per cycle; its result is
// registered when the query leaves the last cell.
// One item at a time; a request is taken only while the result register is free
// or being emptied in the same cycle.
// Reset clears all slot valid bits and the fill count; no clearing pass.
`default_nettype none
module fifo_fully_associative_tlb_top #(
  parameter int ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic                            func,
  input  logic [fatlb_pkg::PID_W-1:0]     pid,
  input  logic [fatlb_pkg::PAGE_W-1:0]    page_number,
  input  logic [fatlb_pkg::FRAME_W-1:0]   frame_in,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic                            hit,
  output logic [fatlb_pkg::FRAME_W-1:0]   frame_out,
  output logic                            evicted
);
  import fatlb_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   fill_count;
  logic               full;
  logic               req_fire;
  logic               ins_fire;
  logic               shift_en;
  entry_t             new_entry;
  entry_t             entry_arr [ENTRIES];
  logic               valid_arr [ENTRIES];
  query_t             q_head;
  query_t             q_chain   [ENTRIES+1];
  query_t             q_exit;

  assign full      = (fill_count == CNT_W'(ENTRIES));
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;
  assign ins_fire  = req_fire && (func == FUNC_INSERT);
  assign shift_en  = ins_fire && full;

  assign new_entry.pid   = pid;
  assign new_entry.page  = page_number;
  assign new_entry.frame = frame_in;

  always_comb begin
    q_head.active = req_fire && (func == FUNC_LOOKUP);
    q_head.pid    = pid;
    q_head.page   = page_number;
    q_head.found  = 1'b0;
    q_head.frame  = '0;
  end

  assign q_chain[0] = q_head;
  assign q_exit     = q_chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t nbr_entry;
    logic   nbr_valid;
    logic   load_en;

    if (i < ENTRIES - 1) begin : g_mid
      assign nbr_entry = entry_arr[i+1];
      assign nbr_valid = valid_arr[i+1];
    end else begin : g_last
      assign nbr_entry = new_entry;
      assign nbr_valid = 1'b1;
    end

    assign load_en = ins_fire && !full && (fill_count[IDX_W-1:0] == IDX_W'(i));

    fatlb_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift_en    (shift_en),
      .load_en     (load_en),
      .new_entry   (new_entry),
      .nbr_entry   (nbr_entry),
      .nbr_valid   (nbr_valid),
      .entry       (entry_arr[i]),
      .entry_valid (valid_arr[i]),
      .q_in        (q_chain[i]),
      .q_out       (q_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (ins_fire && !full) begin
      fill_count <= fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      hit       <= 1'b0;
      frame_out <= '0;
      evicted   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (ins_fire) begin
            rsp_valid <= 1'b1;
            hit       <= 1'b1;
            frame_out <= '0;
            evicted   <= full;
          end else begin
            if (req_fire) begin
              state <= S_LOOK;
            end
            if (rsp_valid && rsp_ready) begin
              rsp_valid <= 1'b0;
            end
          end
        end
        S_LOOK: begin
          if (q_exit.active) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b1;
            hit       <= q_exit.found;
            frame_out <= q_exit.found ? q_exit.frame : '0;
            evicted   <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(ENTRIES))
    else $error("fill count above table size");

  a_look_no_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> !rsp_valid)
    else $error("result pending while lookup walks the chain");

  a_exit_in_look: assert property (@(posedge clk) disable iff (rst)
    q_exit.active |-> (state == S_LOOK))
    else $error("query left the chain outside a lookup");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    ins_fire && full |=> (fill_count == CNT_W'(ENTRIES)) && rsp_valid && evicted && hit)
    else $error("full insert did not report eviction");
`endif

endmodule
`default_nettype wire

// File: dv/fifo_fully_associative_tlb_top_test.sv
// Testbench for the FIFO-replacement TLB: queued driver, checking monitor, shadow table.
`timescale 1ns / 100ps
module fifo_fully_associative_tlb_top_test;
  import fatlb_pkg::*;

  localparam int ENTRIES = 64;
  localparam int KEY_POOL = 24;

  typedef struct {
    logic               func;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_req_t;

  typedef struct {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
  } tlb_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic               func = FUNC_LOOKUP;
  logic [PID_W-1:0]   pid = '0;
  logic [PAGE_W-1:0]  page_number = '0;
  logic [FRAME_W-1:0] frame_in = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic               hit;
  logic [FRAME_W-1:0] frame_out;
  logic               evicted;

  tlb_req_t pending_reqs[$];
  tlb_rsp_t expected_rsps[$];
  int       send_idle_pct = 17;
  int       recv_idle_pct = 79;
  int       errors = 0;

  // shadow translation table, slot 0 oldest
  logic [PID_W-1:0]   shadow_pid[ENTRIES];
  logic [PAGE_W-1:0]  shadow_page[ENTRIES];
  logic [FRAME_W-1:0] shadow_frame[ENTRIES];
  int                 shadow_fill = 0;

  logic [PID_W-1:0]   pool_pid[KEY_POOL];
  logic [PAGE_W-1:0]  pool_page[KEY_POOL];

  fifo_fully_associative_tlb_top #(.ENTRIES(ENTRIES)) DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .func        (func),
    .pid         (pid),
    .page_number (page_number),
    .frame_in    (frame_in),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .hit         (hit),
    .frame_out   (frame_out),
    .evicted     (evicted)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic tlb_rsp_t translate(input tlb_req_t r);
    tlb_rsp_t rsp;
    int       slot;
    rsp.hit = 1'b0;
    rsp.frame = '0;
    rsp.evicted = 1'b0;
    if (r.func == FUNC_LOOKUP) begin
      for (int i = 0; i < shadow_fill; i++) begin
        if (shadow_pid[i] == r.pid && shadow_page[i] == r.page) begin
          rsp.hit = 1'b1;
          rsp.frame = shadow_frame[i];
          break;
        end
      end
    end else begin
      rsp.hit = 1'b1;
      if (shadow_fill < ENTRIES) begin
        slot = shadow_fill;
        shadow_fill++;
      end else begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          shadow_pid[i] = shadow_pid[i+1];
          shadow_page[i] = shadow_page[i+1];
          shadow_frame[i] = shadow_frame[i+1];
        end
        slot = ENTRIES - 1;
        rsp.evicted = 1'b1;
      end
      shadow_pid[slot] = r.pid;
      shadow_page[slot] = r.page;
      shadow_frame[slot] = r.frame;
    end
    return rsp;
  endfunction

  // driver
  always @(posedge clk) begin
    tlb_req_t r;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        r.func = func;
        r.pid = pid;
        r.page = page_number;
        r.frame = frame_in;
        expected_rsps.push_back(translate(r));
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          func <= r.func;
          pid <= r.pid;
          page_number <= r.page;
          frame_in <= r.frame;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tlb_rsp_t e;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transfer: hit %0b frame_out %0h evicted %0b",
                 hit, frame_out, evicted);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (hit !== e.hit) begin
            $error("hit: expected %0b, got %0b", e.hit, hit);
            errors++;
          end
          if (frame_out !== e.frame) begin
            $error("frame_out: expected %0h, got %0h", e.frame, frame_out);
            errors++;
          end
          if (evicted !== e.evicted) begin
            $error("evicted: expected %0b, got %0b", e.evicted, evicted);
            errors++;
          end
        end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic queue_req(input logic f, input logic [PID_W-1:0] p,
                           input logic [PAGE_W-1:0] pg, input logic [FRAME_W-1:0] fr);
    tlb_req_t r;
    r.func = f;
    r.pid = p;
    r.page = pg;
    r.frame = fr;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(negedge clk);
  endtask

  task automatic queue_random(input int count);
    int sel;
    int k;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, KEY_POOL - 1);
      if (sel < 45)
        queue_req(FUNC_INSERT, pool_pid[k], pool_page[k], FRAME_W'($urandom));
      else if (sel < 83)
        queue_req(FUNC_LOOKUP, pool_pid[k], pool_page[k], FRAME_W'($urandom));
      else if (sel < 89)
        queue_req(FUNC_LOOKUP, PID_W'($urandom), PAGE_W'($urandom), FRAME_W'($urandom));
      else if (sel < 93)
        queue_req(FUNC_LOOKUP, pool_pid[k], PAGE_W'($urandom), FRAME_W'($urandom));
      else if (sel < 97)
        queue_req(FUNC_LOOKUP, PID_W'($urandom), pool_page[k], FRAME_W'($urandom));
      else
        queue_req(FUNC_INSERT, PID_W'($urandom), PAGE_W'($urandom), FRAME_W'($urandom));
    end
  endtask

  initial begin
    #2000000;
    $display("** fifo_fully_associative_tlb_top: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_pid[i] = PID_W'($urandom);
      pool_page[i] = PAGE_W'($urandom);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table, key extremes, duplicates, partial key matches
    queue_req(FUNC_LOOKUP, '0, '0, '0);
    queue_req(FUNC_LOOKUP, '1, '1, '1);
    queue_req(FUNC_INSERT, '0, '0, '0);
    queue_req(FUNC_INSERT, '1, '1, '1);
    queue_req(FUNC_LOOKUP, '0, '0, '1);
    queue_req(FUNC_LOOKUP, '1, '1, '0);
    queue_req(FUNC_INSERT, '0, '0, 8'h5a);
    queue_req(FUNC_LOOKUP, '0, '0, 8'h5a);
    queue_req(FUNC_LOOKUP, '0, '1, '0);
    queue_req(FUNC_LOOKUP, '1, '0, '0);
    queue_req(FUNC_INSERT, 16'h1234, 20'habcde, 8'ha5);
    queue_req(FUNC_LOOKUP, 16'h1234, 20'habcde, 8'h3c);
    queue_req(FUNC_LOOKUP, 16'h1234, 20'habcdf, 8'h00);
    queue_random(160);
    drain();

    send_idle_pct = 79;
    recv_idle_pct = 17;
    queue_random(160);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(170);
    drain();

    repeat (3 * ENTRIES) @(negedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("** fifo_fully_associative_tlb_top: PASSED **");
    end else begin
      $display("** fifo_fully_associative_tlb_top: FAILED **");
    end
    $finish;
  end

endmodule
